// ----- rtl/core/hsmc_pkg.sv -----
// Shared types and constants for the hall sensor move controller.
// Holds the phase codes, register map, configuration struct and the hall
// code table. No dependencies.
package hsmc_pkg;

  // Field widths
  localparam int PulseW   = 11;
  localparam int SpmW     = 8;
  localparam int VolW     = 12;
  localparam int WinW     = 7;
  localparam int PosW     = 21;
  localparam int AmountW  = 16;
  localparam int HallW    = 3;
  localparam int KindW    = 2;
  localparam int AddrW    = 5;

  // Item kinds
  localparam logic [KindW-1:0] KIND_SAMPLE   = 2'd0;
  localparam logic [KindW-1:0] KIND_DISPENSE = 2'd1;
  localparam logic [KindW-1:0] KIND_VALVE    = 2'd2;

  // Sequencer phases
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_FWD    = 3'd1;
  localparam logic [2:0] PH_REV    = 3'd2;
  localparam logic [2:0] PH_DELAY  = 3'd3;
  localparam logic [2:0] PH_SETTLE = 3'd4;

  // Neutral delay ends on the tenth tick
  localparam logic [WinW-1:0] DELAY_LAST = 7'd9;

  // Position limits
  localparam logic signed [PosW-1:0] POS_MAX = 21'sh0FFFFF;
  localparam logic signed [PosW-1:0] POS_MIN = 21'sh100000;

  // Register indexes (byte address 4*index)
  localparam logic [2:0] REG_FWD_PULSE = 3'd0;
  localparam logic [2:0] REG_REV_PULSE = 3'd1;
  localparam logic [2:0] REG_NEU_PULSE = 3'd2;
  localparam logic [2:0] REG_STEPS_ML  = 3'd3;
  localparam logic [2:0] REG_MAX_VOL   = 3'd4;
  localparam logic [2:0] REG_SETTLE    = 3'd5;

  // Register reset values
  localparam logic [PulseW-1:0] RST_FWD_PULSE = 11'd1800;
  localparam logic [PulseW-1:0] RST_REV_PULSE = 11'd1420;
  localparam logic [PulseW-1:0] RST_NEU_PULSE = 11'd1500;
  localparam logic [SpmW-1:0]   RST_STEPS_ML  = 8'd135;
  localparam logic [VolW-1:0]   RST_MAX_VOL   = 12'd500;
  localparam logic [WinW-1:0]   RST_SETTLE    = 7'd60;

  // Hall phase marker for codes with no valid phase
  localparam logic [2:0] HALL_NONE = 3'd7;

  typedef struct packed {
    logic [PulseW-1:0] forward_pulse;
    logic [PulseW-1:0] reverse_pulse;
    logic [PulseW-1:0] neutral_pulse;
    logic [SpmW-1:0]   ml_steps;
    logic [VolW-1:0]   max_volume;
    logic [WinW-1:0]   settle_window;
  } cfg_t;

  // Hall code to commutation phase: codes 4,6,2,3,1,5 are phases 0..5
  function automatic logic [2:0] code_to_phase(input logic [HallW-1:0] code);
    logic [2:0] p;
    begin
      case (code)
        3'd4:    p = 3'd0;
        3'd6:    p = 3'd1;
        3'd2:    p = 3'd2;
        3'd3:    p = 3'd3;
        3'd1:    p = 3'd4;
        3'd5:    p = 3'd5;
        default: p = HALL_NONE;
      endcase
      return p;
    end
  endfunction

endpackage

// ----- rtl/core/hsmc_regs.sv -----
// APB-style configuration register file for the move controller.
// Depends on hsmc_pkg for the register map and the cfg_t struct.
module hsmc_regs import hsmc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.forward_pulse <= RST_FWD_PULSE;
      cfg.reverse_pulse <= RST_REV_PULSE;
      cfg.neutral_pulse <= RST_NEU_PULSE;
      cfg.ml_steps      <= RST_STEPS_ML;
      cfg.max_volume    <= RST_MAX_VOL;
      cfg.settle_window <= RST_SETTLE;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_FWD_PULSE: cfg.forward_pulse <= pwdata[PulseW-1:0];
        REG_REV_PULSE: cfg.reverse_pulse <= pwdata[PulseW-1:0];
        REG_NEU_PULSE: cfg.neutral_pulse <= pwdata[PulseW-1:0];
        REG_STEPS_ML:  cfg.ml_steps      <= pwdata[SpmW-1:0];
        REG_MAX_VOL:   cfg.max_volume    <= pwdata[VolW-1:0];
        REG_SETTLE:    cfg.settle_window <= pwdata[WinW-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_idx)
      REG_FWD_PULSE: prdata = {21'd0, cfg.forward_pulse};
      REG_REV_PULSE: prdata = {21'd0, cfg.reverse_pulse};
      REG_NEU_PULSE: prdata = {21'd0, cfg.neutral_pulse};
      REG_STEPS_ML:  prdata = {24'd0, cfg.ml_steps};
      REG_MAX_VOL:   prdata = {20'd0, cfg.max_volume};
      REG_SETTLE:    prdata = {25'd0, cfg.settle_window};
      default:       prdata = 32'd0;
    endcase
  end

endmodule

// ----- rtl/core/hsmc_hall_dec.sv -----
// Hall code decoder with saturating step counter update.
// Depends on hsmc_pkg for the code table and position limits.
module hsmc_hall_dec import hsmc_pkg::*; (
  input  logic [HallW-1:0]       hall_code,
  input  logic [2:0]             hall_phase,
  input  logic signed [PosW-1:0] step_count,
  output logic [2:0]             hall_phase_next,
  output logic signed [PosW-1:0] step_count_next
);

  logic [2:0] p;
  logic [2:0] fwd_phase;
  logic [2:0] rev_phase;
  logic       step_up;
  logic       step_dn;

  assign p         = code_to_phase(hall_code);
  // neighbors of the current phase on the six-state ring
  assign fwd_phase = (hall_phase == 3'd5) ? 3'd0 : hall_phase + 3'd1;
  assign rev_phase = (hall_phase == 3'd0) ? 3'd5 : hall_phase - 3'd1;
  assign step_up   = (p != HALL_NONE) && (p == fwd_phase);
  assign step_dn   = (p != HALL_NONE) && !step_up && (p == rev_phase);

  always_comb begin
    hall_phase_next = (p == HALL_NONE) ? hall_phase : p;
    step_count_next = step_count;
    if (step_up && step_count != POS_MAX) begin
      step_count_next = step_count + 21'sd1;
    end else if (step_dn && step_count != POS_MIN) begin
      step_count_next = step_count - 21'sd1;
    end
  end

endmodule

// ----- rtl/core/hall_sensor_move_controller.sv -----
// Top level of the hall sensor move controller: stream ports, move sequencer.
// Depends on hsmc_pkg, hsmc_regs and hsmc_hall_dec.
//
//  Channel  Signals                          Contents
//  s        s_tvalid s_tready s_tdata s_tuser  one sensor sample or command
//  m        m_tvalid m_tready m_tdata          pulse width, status, position
//  cfg      psel penable pwrite paddr ...      six control registers
//
// One item per cycle sustained while m is not stalled; each item passes the
// input register, then the decode/sequencer logic into the result register.
// The state update of one item is complete when that item fires, so items may follow
// back to back. A stall on m holds the result and backs up into s_tready.
// Synchronous reset clears the sequencer to idle and the registers to their
// default values.
module hall_sensor_move_controller import hsmc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [23:0]      s_tdata,   // hall_code[2:0], ms_tick[3], amount[19:4], zero pad
  input  logic [1:0]       s_tuser,   // kind[1:0]
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [39:0]      m_tdata,   // pulse_width[10:0], busy_res[11], done_res[12],
                                      // position[33:13], zero pad
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t cfg;

  // Input register
  logic                      in_valid;
  logic [KindW-1:0]          in_kind;
  logic [HallW-1:0]          in_hall;
  logic                      in_tick;
  logic signed [AmountW-1:0] in_amount;

  // Sequencer state
  logic [2:0]             hall_phase, hall_phase_next;
  logic signed [PosW-1:0] step_count, step_count_next;
  logic signed [PosW-1:0] goal_count, goal_count_next;
  logic signed [PosW-1:0] last_check_count, last_check_count_next;
  logic [2:0]             phase, phase_next;
  logic [WinW-1:0]        ms_count, ms_count_next;
  logic                   trailing_dispense, trailing_dispense_next;
  logic                   done_next;
  logic [PulseW-1:0]      pw_next;

  logic                   advance;
  logic                   fire;
  logic [2:0]             dec_phase;
  logic signed [PosW-1:0] dec_step;
  logic [VolW-1:0]        vol;
  logic [19:0]            disp_goal;
  logic signed [PosW-1:0] one_ml_goal;

  hsmc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hsmc_hall_dec u_hall (
    .hall_code       (in_hall),
    .hall_phase      (hall_phase),
    .step_count      (step_count),
    .hall_phase_next (dec_phase),
    .step_count_next (dec_step)
  );

  // Handshake: result register frees when empty or taken
  assign advance  = !m_tvalid || m_tready;
  assign fire     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind   <= s_tuser;
      in_hall   <= s_tdata[2:0];
      in_tick   <= s_tdata[3];
      in_amount <= s_tdata[19:4];
    end
  end

  // Dispense volume clamp and goal
  always_comb begin
    if (in_amount[AmountW-1]) begin
      vol = '0;
    end else if (in_amount[AmountW-2:0] > {3'd0, cfg.max_volume}) begin
      vol = cfg.max_volume;
    end else begin
      vol = in_amount[VolW-1:0];
    end
  end

  assign disp_goal   = {8'd0, vol} * {12'd0, cfg.ml_steps};
  assign one_ml_goal = (cfg.max_volume != '0) ? {13'd0, cfg.ml_steps} : '0;

  // Sequencer next state
  always_comb begin
    hall_phase_next        = hall_phase;
    step_count_next        = step_count;
    goal_count_next        = goal_count;
    last_check_count_next  = last_check_count;
    phase_next             = phase;
    ms_count_next          = ms_count;
    trailing_dispense_next = trailing_dispense;
    done_next              = 1'b0;

    if (phase == PH_IDLE && in_kind == KIND_DISPENSE) begin
      step_count_next = '0;
      goal_count_next = {1'b0, disp_goal};
      ms_count_next   = '0;
      phase_next      = (disp_goal != '0) ? PH_FWD : PH_DELAY;
    end else if (phase == PH_IDLE && in_kind == KIND_VALVE) begin
      step_count_next        = '0;
      goal_count_next        = {{(PosW-AmountW){in_amount[AmountW-1]}}, in_amount};
      ms_count_next          = '0;
      trailing_dispense_next = 1'b1;
      phase_next             = in_amount[AmountW-1] ? PH_REV : PH_DELAY;
    end else begin
      hall_phase_next = dec_phase;
      step_count_next = dec_step;
      unique case (phase)
        PH_FWD: begin
          if (dec_step >= goal_count) begin
            phase_next    = PH_DELAY;
            ms_count_next = '0;
          end
        end
        PH_REV: begin
          if (dec_step <= goal_count) begin
            phase_next    = PH_DELAY;
            ms_count_next = '0;
          end
        end
        PH_DELAY: begin
          if (in_tick) begin
            if (ms_count >= DELAY_LAST) begin
              phase_next    = PH_SETTLE;
              ms_count_next = '0;
            end else begin
              ms_count_next = ms_count + 7'd1;
            end
          end
        end
        PH_SETTLE: begin
          if (in_tick) begin
            if (ms_count >= cfg.settle_window) begin
              ms_count_next = '0;
              if (dec_step == last_check_count) begin
                if (trailing_dispense) begin
                  // valve move done: run the one-ml follow-up dispense
                  trailing_dispense_next = 1'b0;
                  step_count_next        = '0;
                  goal_count_next        = one_ml_goal;
                  phase_next             = (one_ml_goal != '0) ? PH_FWD : PH_DELAY;
                end else begin
                  phase_next = PH_IDLE;
                  done_next  = 1'b1;
                end
              end else begin
                last_check_count_next = dec_step;
              end
            end else begin
              ms_count_next = ms_count + 7'd1;
            end
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  // Pulse width follows the new phase
  always_comb begin
    if (phase_next == PH_FWD) begin
      pw_next = cfg.forward_pulse;
    end else if (phase_next == PH_REV) begin
      pw_next = cfg.reverse_pulse;
    end else begin
      pw_next = cfg.neutral_pulse;
    end
  end

  // State update, one item per fire
  always_ff @(posedge clk) begin
    if (rst) begin
      hall_phase        <= '0;
      step_count        <= '0;
      goal_count        <= '0;
      last_check_count  <= '0;
      phase             <= PH_IDLE;
      ms_count          <= '0;
      trailing_dispense <= 1'b0;
    end else if (fire) begin
      hall_phase        <= hall_phase_next;
      step_count        <= step_count_next;
      goal_count        <= goal_count_next;
      last_check_count  <= last_check_count_next;
      phase             <= phase_next;
      ms_count          <= ms_count_next;
      trailing_dispense <= trailing_dispense_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {6'd0, step_count_next, done_next, (phase_next != PH_IDLE), pw_next};
    end
  end

endmodule

// ----- rtl/core/hsmc_checker.sv -----
// Port-level checks for the hall sensor move controller, bound to the top.
// Depends only on the top level's ports.
module hsmc_port_checks (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        pready
);

  // A held result does not change while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Finishing an item leaves the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[12] |-> !m_tdata[11])
    else $error("done raised while busy");

  // Padding bits stay zero
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[39:34] == 6'd0)
    else $error("nonzero padding in result");

  // Configuration port never waits
  a_pready: assert property (@(posedge clk) disable iff (rst)
    pready)
    else $error("configuration port not ready");

endmodule

bind hall_sensor_move_controller hsmc_port_checks u_hsmc_port_checks (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .pready   (pready)
);
